// File: rtl/rbpm_pkg.sv
package rbpm_pkg;

    localparam int unsigned FIELD_W  = 21;
    localparam int unsigned OFFSET_W = 20;
    localparam int unsigned CFG_IDX_W = 4;

    typedef logic [FIELD_W-1:0]   t_field;
    typedef logic [OFFSET_W-1:0]  t_offset;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_RING_SIZE    = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_MAX_TRANSFER = t_cfg_idx'(1);

    localparam t_field RING_SIZE_RESET    = t_field'(1048576);
    localparam t_field MAX_TRANSFER_RESET = t_field'(65536);

    typedef enum logic [1:0] {
        FILL_EMPTY   = 2'd0,
        FILL_PARTIAL = 2'd1,
        FILL_FULL    = 2'd2
    } t_fill;

    typedef enum logic [1:0] {
        RES_GRANT     = 2'd0,
        RES_BLOCK     = 2'd1,
        RES_PEER_GONE = 2'd2
    } t_result;

    // request class decided at the front, before the ring state is known
    typedef enum logic [1:0] {
        OP_READ         = 2'd0,
        OP_WRITE        = 2'd1,
        OP_WRITE_REFUSE = 2'd2
    } t_op;

    typedef struct packed {
        t_op    op;
        logic   peer;
        t_field count;
    } t_cmd;

endpackage

// File: rtl/rbpm_intf.sv
interface rbpm_req_if import rbpm_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   req_type;
    t_field count;
    logic   peer_present;

    modport source (output valid, output req_type, output count, output peer_present,
                    input ready);
    modport sink   (input valid, input req_type, input count, input peer_present,
                    output ready);
endinterface

interface rbpm_rsp_if import rbpm_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] result_code;
    t_field     granted;
    t_offset    first_offset;
    t_field     first_length;
    t_field     second_length;
    logic [1:0] fill_state;

    modport source (output valid, output result_code, output granted, output first_offset,
                    output first_length, output second_length, output fill_state,
                    input ready);
    modport sink   (input valid, input result_code, input granted, input first_offset,
                    input first_length, input second_length, input fill_state,
                    output ready);
endinterface

interface rbpm_cfg_if import rbpm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_field   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/ring_buffer_pointer_manager.sv
// pointer manager for a single-producer single-consumer byte ring
// i_req: one beat per request (req_type 0 read, 1 write, count, peer_present)
// o_rsp: one beat per request, in order: result code, grant, start offset,
//   the two segment lengths split at the wrap, and the fill state afterwards
// i_cfg: register writes (index 0 ring size, index 1 max transfer), always
//   ready; write only while no request is in flight; a ring size write
//   empties the ring
// a request is written into a two-entry command queue when it is accepted and
// is executed from the queue head into the output register once that register
// is empty or its response is being taken
// one request per cycle is sustained while o_rsp.ready stays high; the grant,
// split and pointer update are combinational in the back end, from the queue head
// when o_rsp.ready is low the response holds, the back end stops, and the
// queue fills; i_req.ready drops once both queue entries are taken
// reset empties the ring, clears the queue and the output valid, and
// loads ring size 1048576 and max transfer 65536
module ring_buffer_pointer_manager import rbpm_pkg::*; #(
    parameter int unsigned POINTER_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rbpm_req_if.sink    i_req,
    rbpm_cfg_if.sink    i_cfg,
    rbpm_rsp_if.source  o_rsp
);

    logic w_push;
    logic w_q_ready;
    t_cmd w_push_cmd;
    logic w_q_valid;
    t_cmd w_head_cmd;
    logic w_pop;

    rbpm_front u_front (
        .i_req     (i_req),
        .i_q_ready (w_q_ready),
        .o_q_valid (w_push),
        .o_cmd     (w_push_cmd)
    );

    rbpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_head_cmd)
    );

    rbpm_back #(
        .POINTER_BITS (POINTER_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_cmd     (w_head_cmd),
        .o_q_pop   (w_pop),
        .i_cfg     (i_cfg),
        .o_rsp     (o_rsp)
    );

endmodule

// File: rtl/rbpm_front.sv
module rbpm_front import rbpm_pkg::*; (
    rbpm_req_if.sink i_req,
    input  logic     i_q_ready,
    output logic     o_q_valid,
    output t_cmd     o_cmd
);

    assign i_req.ready = i_q_ready;
    assign o_q_valid   = i_req.valid;

    // a write with the reader gone is refused whatever the fill state
    always_comb begin
        o_cmd.peer  = i_req.peer_present;
        o_cmd.count = i_req.count;
        if (!i_req.req_type) begin
            o_cmd.op = OP_READ;
        end else if (!i_req.peer_present) begin
            o_cmd.op = OP_WRITE_REFUSE;
        end else begin
            o_cmd.op = OP_WRITE;
        end
    end

endmodule

// File: rtl/rbpm_queue.sv
module rbpm_queue import rbpm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: rtl/rbpm_back.sv
module rbpm_back import rbpm_pkg::*; #(
    parameter int unsigned POINTER_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cmd        i_cmd,
    output logic        o_q_pop,
    rbpm_cfg_if.sink    i_cfg,
    rbpm_rsp_if.source  o_rsp
);

    // working width: holds the ring size, a pointer plus a grant, and a field
    localparam int unsigned SW = (POINTER_BITS + 2 > 22) ? POINTER_BITS + 2 : 22;
    localparam logic [SW-1:0] CAP = {{(SW-POINTER_BITS-1){1'b0}}, 1'b1, {POINTER_BITS{1'b0}}};
    localparam logic [SW-1:0] MIN_SIZE = SW'(2);

    t_field                  r_ring_size;
    t_field                  r_max_transfer;
    logic [POINTER_BITS-1:0] r_rd_ptr;
    logic [POINTER_BITS-1:0] r_wr_ptr;
    t_fill                   r_fill;

    logic       r_out_valid;
    t_result    r_code;
    t_field     r_granted;
    t_offset    r_offset;
    t_field     r_len1;
    t_field     r_len2;
    t_fill      r_out_fill;

    logic          w_fire;
    logic          w_blocked;
    t_result       w_block_code;
    logic          w_is_write;
    logic [SW-1:0] w_raw_size;
    logic [SW-1:0] w_size;
    logic [SW-1:0] w_ptr;
    logic [SW-1:0] w_other;
    logic [SW-1:0] w_avail;
    logic [SW-1:0] w_lim;
    logic [SW-1:0] w_n;
    logic [SW-1:0] w_to_end;
    logic [SW-1:0] w_n1;
    logic [SW-1:0] w_sum;
    logic [SW-1:0] w_next;
    logic [POINTER_BITS-1:0] n_rd_ptr;
    logic [POINTER_BITS-1:0] n_wr_ptr;
    t_fill         n_fill;

    assign i_cfg.ready = 1'b1;
    assign o_q_pop     = i_q_valid && (!r_out_valid || o_rsp.ready);
    assign w_fire      = o_q_pop;
    assign w_is_write  = (i_cmd.op != OP_READ);

    always_comb begin
        w_raw_size = SW'(r_ring_size);
        if (w_raw_size < MIN_SIZE) begin
            w_size = MIN_SIZE;
        end else if (w_raw_size > CAP) begin
            w_size = CAP;
        end else begin
            w_size = w_raw_size;
        end
    end

    always_comb begin
        w_blocked    = 1'b0;
        w_block_code = RES_GRANT;
        case (i_cmd.op)
            OP_READ: begin
                if (r_fill == FILL_EMPTY) begin
                    w_blocked    = 1'b1;
                    w_block_code = i_cmd.peer ? RES_BLOCK : RES_PEER_GONE;
                end
            end
            OP_WRITE: begin
                if (r_fill == FILL_FULL) begin
                    w_blocked    = 1'b1;
                    w_block_code = RES_BLOCK;
                end
            end
            default: begin
                w_blocked    = 1'b1;
                w_block_code = RES_PEER_GONE;
            end
        endcase
    end

    always_comb begin
        w_ptr   = w_is_write ? SW'(r_wr_ptr) : SW'(r_rd_ptr);
        w_other = w_is_write ? SW'(r_rd_ptr) : SW'(r_wr_ptr);
        if (w_ptr < w_other) begin
            w_avail = w_other - w_ptr;
        end else begin
            w_avail = w_size + w_other - w_ptr;
        end
        w_lim    = (w_avail < SW'(r_max_transfer)) ? w_avail : SW'(r_max_transfer);
        w_n      = (w_lim < SW'(i_cmd.count)) ? w_lim : SW'(i_cmd.count);
        w_to_end = w_size - w_ptr;
        w_n1     = (w_to_end < w_n) ? w_to_end : w_n;
        w_sum    = w_ptr + w_n;
        w_next   = (w_sum >= w_size) ? (w_sum - w_size) : w_sum;
    end

    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_fill   = r_fill;
        if (!w_blocked && (w_n != '0)) begin
            if (w_is_write) begin
                n_wr_ptr = w_next[POINTER_BITS-1:0];
            end else begin
                n_rd_ptr = w_next[POINTER_BITS-1:0];
            end
            if (n_rd_ptr == n_wr_ptr) begin
                n_fill = w_is_write ? FILL_FULL : FILL_EMPTY;
            end else begin
                n_fill = FILL_PARTIAL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size    <= RING_SIZE_RESET;
            r_max_transfer <= MAX_TRANSFER_RESET;
            r_rd_ptr       <= '0;
            r_wr_ptr       <= '0;
            r_fill         <= FILL_EMPTY;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid && (i_cfg.index == CFG_RING_SIZE)) begin
                // resizing empties the ring
                r_ring_size <= i_cfg.data;
                r_rd_ptr    <= '0;
                r_wr_ptr    <= '0;
                r_fill      <= FILL_EMPTY;
            end else if (w_fire) begin
                r_rd_ptr <= n_rd_ptr;
                r_wr_ptr <= n_wr_ptr;
                r_fill   <= n_fill;
            end
            if (i_cfg.valid && (i_cfg.index == CFG_MAX_TRANSFER)) begin
                r_max_transfer <= i_cfg.data;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_fill <= n_fill;
            if (w_blocked) begin
                r_code    <= w_block_code;
                r_granted <= '0;
                r_offset  <= '0;
                r_len1    <= '0;
                r_len2    <= '0;
            end else begin
                r_code    <= RES_GRANT;
                r_granted <= w_n[FIELD_W-1:0];
                r_offset  <= w_ptr[OFFSET_W-1:0];
                r_len1    <= w_n1[FIELD_W-1:0];
                r_len2    <= w_n[FIELD_W-1:0] - w_n1[FIELD_W-1:0];
            end
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.result_code   = r_code;
    assign o_rsp.granted       = r_granted;
    assign o_rsp.first_offset  = r_offset;
    assign o_rsp.first_length  = r_len1;
    assign o_rsp.second_length = r_len2;
    assign o_rsp.fill_state    = r_out_fill;

endmodule

// File: rtl/rbpm_checker.sv
module rbpm_checker import rbpm_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic [1:0] i_result_code,
    input t_field     i_granted,
    input t_field     i_first_length,
    input t_field     i_second_length,
    input logic [1:0] i_fill_state
);

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_granted)
            && $stable(i_result_code))
        else $error("response changed while stalled");

    // nothing comes out right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_result_code != RES_GRANT) |-> (i_granted == '0)
            && (i_first_length == '0) && (i_second_length == '0))
        else $error("refused request carries a grant");

    a_split_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> ({1'b0, i_granted} ==
            ({1'b0, i_first_length} + {1'b0, i_second_length})))
        else $error("segment lengths do not add up to the grant");

    // after a nonzero grant the fill state must be one of the three defined codes
    a_grant_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_result_code == RES_GRANT) && (i_granted != '0)
            |-> (i_fill_state == FILL_PARTIAL) || (i_fill_state == FILL_EMPTY)
                || (i_fill_state == FILL_FULL))
        else $error("bad fill state after a grant");

endmodule

bind ring_buffer_pointer_manager rbpm_checker u_rbpm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_result_code   (o_rsp.result_code),
    .i_granted       (o_rsp.granted),
    .i_first_length  (o_rsp.first_length),
    .i_second_length (o_rsp.second_length),
    .i_fill_state    (o_rsp.fill_state)
);
